// ===== hdl/crv_pkg.sv =====
// Shared types for the contact repulsion velocity block.
// Holds the sequencer state type and the status bundle of the serial units.
// No dependencies.
`default_nettype none

package crv_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SQX,
    ST_SQY,
    ST_SQRT,
    ST_AA,
    ST_DIVQ,
    ST_MAG,
    ST_UX,
    ST_CX,
    ST_UY,
    ST_CY,
    ST_FIN
  } crv_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } crv_stat_t;

endpackage

`default_nettype wire

// ===== hdl/contact_repulsion_velocity.sv =====
// Top level of the contact repulsion velocity accumulator.
// Depends on crv_pkg, crv_mul, crv_div and crv_sqrt.
//
// Each input request describes one focal disc and one neighbor disc; a neighbor that overlaps
// the focal disc adds a repulsive push to a 48-bit saturating sum, and the request marked by
// tlast emits that sum saturated to 32 bits per axis and clears it. A request that is skipped
// as self or outside the bounding box returns to idle without the square root, and one found
// coincident or not overlapping returns after the square root. A contributing request runs
// through the serial units: six products on the bit-serial multiplier, a square root and three
// quotients on the bit-serial divider, plus the sequencing states. One request is worked on at
// a time; a finished result waits in the output register while the next request is accepted,
// and a request marked tlast stalls in its final cycle while an earlier result still occupies
// that register.
`default_nettype none

module contact_repulsion_velocity import crv_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [23:0]  cfg_data_i,      // stiffness
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // self_x, self_y, self_radius, other_x, other_y, other_radius
  input  wire logic [175:0] s_axis_tdata_i,
  input  wire logic         s_axis_tuser_i,  // is_self
  input  wire logic         s_axis_tlast_i,  // last
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic      [63:0]  m_axis_tdata_o   // vel_x, vel_y
);

  localparam int unsigned RadW    = 24;
  localparam int unsigned TW      = RadW + 1;
  localparam int unsigned DiffW   = 33;
  localparam int unsigned SqW     = 2 * TW;
  localparam int unsigned RootW   = TW + 1;
  localparam int unsigned StqW    = RadW + TW;
  localparam int unsigned MagW    = StqW - FRAC_BITS;
  localparam int unsigned MulB    = TW;
  localparam int unsigned MulP    = MagW + MulB;
  localparam int unsigned DivN    = 2 * TW;
  localparam int unsigned AccW    = 48;
  localparam int unsigned StiffRst = 327680;

  crv_state_e state_q, state_d;

  logic [RadW-1:0]         stiff_q;
  logic [TW-1:0]           t_q, t_d, adx_q, adx_d, ady_q, ady_d, dist_q, dist_d;
  logic signed [DiffW-1:0] dx_q, dx_d, dy_q, dy_d;
  logic                    self_q, self_d, last_q, last_d;
  logic [SqW-1:0]          sq_q, sq_d;
  logic [MagW-1:0]         mag_q, mag_d;
  logic signed [AccW-1:0]  acc_x_q, acc_x_d, acc_y_q, acc_y_d;
  logic                    out_valid_q, out_valid_d, out_load;
  logic [63:0]             out_data_q, out_data_d;

  logic [DiffW-1:0]        adx_w, ady_w;
  logic [MagW-1:0]         cx_w;
  logic signed [AccW-1:0]  acc_sum;
  logic                    acc_neg;

  logic                    mul_start, div_start, sqrt_start;
  logic [MagW-1:0]         mul_a;
  logic [MulB-1:0]         mul_b;
  logic [MulP-1:0]         mul_prod;
  logic [DivN-1:0]         div_num, div_quo;
  logic [TW-1:0]           div_den;
  logic [2*RootW-1:0]      sqrt_val;
  logic [RootW-1:0]        sqrt_root;
  crv_stat_t               mul_stat, div_stat, sqrt_stat;

  function automatic logic signed [AccW-1:0] acc_add(logic signed [AccW-1:0] acc,
                                                     logic [MagW-1:0] mag, logic neg);
    logic signed [AccW:0] ext;
    logic signed [AccW:0] sum;
    ext = (AccW+1)'(mag);
    sum = {acc[AccW-1], acc} + (neg ? -ext : ext);
    if (sum[AccW] != sum[AccW-1]) begin
      acc_add = sum[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      acc_add = sum[AccW-1:0];
    end
  endfunction

  function automatic logic [31:0] sat32(logic signed [AccW-1:0] acc);
    if (acc[AccW-1:31] == '0 || acc[AccW-1:31] == '1) begin
      sat32 = acc[31:0];
    end else begin
      sat32 = acc[AccW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
  endfunction

  assign adx_w   = dx_q[DiffW-1] ? DiffW'(-dx_q) : DiffW'(dx_q);
  assign ady_w   = dy_q[DiffW-1] ? DiffW'(-dy_q) : DiffW'(dy_q);
  assign cx_w    = mul_prod[FRAC_BITS +: MagW];
  assign acc_neg = (state_q == ST_CX) ? !dx_q[DiffW-1] : !dy_q[DiffW-1];
  assign acc_sum = acc_add((state_q == ST_CX) ? acc_x_q : acc_y_q, cx_w, acc_neg);

  always_comb begin
    state_d     = state_q;
    t_d         = t_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    self_d      = self_q;
    last_d      = last_q;
    adx_d       = adx_q;
    ady_d       = ady_q;
    sq_d        = sq_q;
    dist_d      = dist_q;
    mag_d       = mag_q;
    acc_x_d     = acc_x_q;
    acc_y_d     = acc_y_q;
    out_load    = 1'b0;
    mul_start   = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = dist_q;
    sqrt_start  = 1'b0;
    sqrt_val    = '0;
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          t_d    = TW'(s_axis_tdata_i[87:64]) + TW'(s_axis_tdata_i[175:152]);
          dx_d   = {s_axis_tdata_i[119], s_axis_tdata_i[119:88]}
                 - {s_axis_tdata_i[31], s_axis_tdata_i[31:0]};
          dy_d   = {s_axis_tdata_i[151], s_axis_tdata_i[151:120]}
                 - {s_axis_tdata_i[63], s_axis_tdata_i[63:32]};
          self_d = s_axis_tuser_i;
          last_d = s_axis_tlast_i;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (self_q || adx_w > DiffW'(t_q) || ady_w > DiffW'(t_q)) begin
          state_d = ST_FIN;
        end else begin
          adx_d     = adx_w[TW-1:0];
          ady_d     = ady_w[TW-1:0];
          mul_start = 1'b1;
          mul_a     = MagW'(adx_w[TW-1:0]);
          mul_b     = adx_w[TW-1:0];
          state_d   = ST_SQX;
        end
      end
      ST_SQX: begin
        if (mul_stat.done) begin
          sq_d      = mul_prod[SqW-1:0];
          mul_start = 1'b1;
          mul_a     = MagW'(ady_q);
          mul_b     = ady_q;
          state_d   = ST_SQY;
        end
      end
      ST_SQY: begin
        if (mul_stat.done) begin
          sqrt_start = 1'b1;
          sqrt_val   = (2*RootW)'(sq_q) + (2*RootW)'(mul_prod[SqW-1:0]);
          state_d    = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sqrt_stat.done) begin
          if (sqrt_root == '0 || sqrt_root >= RootW'(t_q)) begin
            state_d = ST_FIN;
          end else begin
            dist_d    = sqrt_root[TW-1:0];
            mul_start = 1'b1;
            mul_a     = MagW'(t_q - sqrt_root[TW-1:0]);
            mul_b     = t_q - sqrt_root[TW-1:0];
            state_d   = ST_AA;
          end
        end
      end
      ST_AA: begin
        if (mul_stat.done) begin
          div_start = 1'b1;
          div_num   = mul_prod[DivN-1:0];
          div_den   = t_q;
          state_d   = ST_DIVQ;
        end
      end
      ST_DIVQ: begin
        if (div_stat.done) begin
          mul_start = 1'b1;
          mul_a     = MagW'(stiff_q);
          mul_b     = div_quo[TW-1:0];
          state_d   = ST_MAG;
        end
      end
      ST_MAG: begin
        if (mul_stat.done) begin
          mag_d     = mul_prod[FRAC_BITS +: MagW];
          div_start = 1'b1;
          div_num   = DivN'({adx_q, {FRAC_BITS{1'b0}}});
          state_d   = ST_UX;
        end
      end
      ST_UX: begin
        if (div_stat.done) begin
          mul_start = 1'b1;
          mul_a     = mag_q;
          mul_b     = MulB'(div_quo[FRAC_BITS:0]);
          state_d   = ST_CX;
        end
      end
      ST_CX: begin
        if (mul_stat.done) begin
          acc_x_d   = acc_sum;
          div_start = 1'b1;
          div_num   = DivN'({ady_q, {FRAC_BITS{1'b0}}});
          state_d   = ST_UY;
        end
      end
      ST_UY: begin
        if (div_stat.done) begin
          mul_start = 1'b1;
          mul_a     = mag_q;
          mul_b     = MulB'(div_quo[FRAC_BITS:0]);
          state_d   = ST_CY;
        end
      end
      ST_CY: begin
        if (mul_stat.done) begin
          acc_y_d = acc_sum;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          acc_x_d  = '0;
          acc_y_d  = '0;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready_i);
  assign out_data_d  = out_load ? {sat32(acc_y_q), sat32(acc_x_q)} : out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stiff_q     <= RadW'(StiffRst);
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_valid_i) begin
        stiff_q <= cfg_data_i;
      end
      acc_x_q     <= acc_x_d;
      acc_y_q     <= acc_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q        <= t_d;
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    self_q     <= self_d;
    last_q     <= last_d;
    adx_q      <= adx_d;
    ady_q      <= ady_d;
    sq_q       <= sq_d;
    dist_q     <= dist_d;
    mag_q      <= mag_d;
    out_data_q <= out_data_d;
  end

  crv_mul #(.WidthA(MagW), .WidthB(MulB)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .stat_o  (mul_stat),
    .prod_o  (mul_prod)
  );

  crv_div #(.WidthN(DivN), .WidthD(TW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .stat_o  (div_stat),
    .quo_o   (div_quo)
  );

  crv_sqrt #(.WidthR(RootW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .val_i   (sqrt_val),
    .stat_o  (sqrt_stat),
    .root_o  (sqrt_root)
  );

  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_mul_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_stat.busy)
    else $error("Multiplier started while busy.");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("Divider started while busy.");

  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (acc_x_q == '0 && acc_y_q == '0))
    else $error("Accumulators not cleared after a result was emitted.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && last_q && out_valid_q && !m_axis_tready_i) |=> state_q == ST_FIN)
    else $error("Result dropped while the output register was full.");

endmodule

`default_nettype wire

// ===== hdl/crv_mul.sv =====
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on crv_pkg for the status bundle.
`default_nettype none

module crv_mul import crv_pkg::*; #(
  parameter int unsigned WidthA = 41,
  parameter int unsigned WidthB = 25
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [WidthA-1:0]          a_i,
  input  wire logic [WidthB-1:0]          b_i,
  output crv_stat_t                       stat_o,
  output logic      [WidthA+WidthB-1:0]   prod_o
);

  localparam int unsigned ProdW = WidthA + WidthB;
  localparam int unsigned CntW  = $clog2(WidthB + 1);

  logic [ProdW-1:0]  a_q, a_d, prod_q, prod_d;
  logic [WidthB-1:0] b_q, b_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    prod_d = prod_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = ProdW'(a_i);
      b_d    = b_i;
      prod_d = '0;
      cnt_d  = CntW'(WidthB);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q[0]) begin
        prod_d = prod_q + a_q;
      end
      a_d   = a_q << 1;
      b_d   = b_q >> 1;
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    prod_q <= prod_d;
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ===== hdl/crv_div.sv =====
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on crv_pkg for the status bundle.
`default_nettype none

module crv_div import crv_pkg::*; #(
  parameter int unsigned WidthN = 50,
  parameter int unsigned WidthD = 25
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [WidthN-1:0] num_i,
  input  wire logic [WidthD-1:0] den_i,
  output crv_stat_t              stat_o,
  output logic      [WidthN-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(WidthN + 1);

  logic [WidthN-1:0] n_q, n_d;
  logic [WidthD-1:0] rem_q, rem_d, den_q, den_d;
  logic [WidthD:0]   trial, diff;
  logic              ge;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;

  assign trial = {rem_q, n_q[WidthN-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_comb begin
    n_d    = n_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      n_d    = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(WidthN);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[WidthD-1:0] : trial[WidthD-1:0];
      n_d   = {n_q[WidthN-2:0], ge};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign quo_o  = n_q;

endmodule

`default_nettype wire

// ===== hdl/crv_sqrt.sv =====
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on crv_pkg for the status bundle.
`default_nettype none

module crv_sqrt import crv_pkg::*; #(
  parameter int unsigned WidthR = 26
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [2*WidthR-1:0] val_i,
  output crv_stat_t                stat_o,
  output logic      [WidthR-1:0]   root_o
);

  localparam int unsigned CntW = $clog2(WidthR + 1);

  logic [2*WidthR-1:0] v_q, v_d;
  logic [WidthR:0]     rem_q, rem_d;
  logic [WidthR-1:0]   res_q, res_d;
  logic [WidthR+2:0]   trial_rem, trial, diff;
  logic                ge;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                busy_q, busy_d, done_q, done_d;

  assign trial_rem = {rem_q, v_q[2*WidthR-1 -: 2]};
  assign trial     = {1'b0, res_q, 2'b01};
  assign diff      = trial_rem - trial;
  assign ge        = (trial_rem >= trial);

  always_comb begin
    v_d    = v_q;
    rem_d  = rem_q;
    res_d  = res_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      v_d    = val_i;
      rem_d  = '0;
      res_d  = '0;
      cnt_d  = CntW'(WidthR);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[WidthR:0] : trial_rem[WidthR:0];
      res_d = {res_q[WidthR-2:0], ge};
      v_d   = v_q << 2;
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    rem_q <= rem_d;
    res_q <= res_d;
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign root_o = res_q;

endmodule

`default_nettype wire

// ===== tb/crv_checker.sv =====
// Scoreboard for the contact repulsion velocity block: watches the configuration,
// input and output channels, predicts each emitted velocity and compares it.
// Depends on nothing but the port widths of contact_repulsion_velocity.
module crv_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  input  wire logic         cfg_ready_i,
  input  wire logic [23:0]  cfg_data_i,
  input  wire logic         s_tvalid_i,
  input  wire logic         s_tready_i,
  input  wire logic [175:0] s_tdata_i,
  input  wire logic         s_tuser_i,
  input  wire logic         s_tlast_i,
  input  wire logic         m_tvalid_i,
  input  wire logic         m_tready_i,
  input  wire logic [63:0]  m_tdata_i,
  input  wire logic         end_i,
  output int                fail_count_o,
  output int                pending_o
);

  localparam int FRAC = 16;
  localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  logic [23:0]  stiff_q;
  longint       sum_x;
  longint       sum_y;
  logic [63:0]  vel_q[$];
  int           fails;
  bit           end_seen;

  assign fail_count_o = fails;
  assign pending_o    = vel_q.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    fails++;
    $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint push_part(input longint unsigned mag, input longint d,
                                       input longint unsigned span);
    longint unsigned ad;
    longint unsigned unit;
    longint          c;
    ad   = (d < 0) ? -d : d;
    unit = (ad << FRAC) / span;
    c    = longint'((mag * unit) >> FRAC);
    return (d > 0) ? -c : c;
  endfunction

  function automatic longint clamp_sum(input longint v);
    if (v > SUM_MAX) return SUM_MAX;
    if (v < SUM_MIN) return SUM_MIN;
    return v;
  endfunction

  function automatic logic [31:0] clamp_out(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  task automatic add_neighbor(input logic [175:0] d);
    longint          sx, sy, ox, oy, dx, dy, adx, ady, touch;
    longint unsigned span, a, q, mag;
    sx    = longint'($signed(d[31:0]));
    sy    = longint'($signed(d[63:32]));
    ox    = longint'($signed(d[119:88]));
    oy    = longint'($signed(d[151:120]));
    touch = longint'(d[87:64]) + longint'(d[175:152]);
    dx    = ox - sx;
    dy    = oy - sy;
    adx   = (dx < 0) ? -dx : dx;
    ady   = (dy < 0) ? -dy : dy;
    if (adx <= touch && ady <= touch) begin
      span = int_sqrt(adx * adx + ady * ady);
      if (span != 0 && span < touch) begin
        a   = touch - span;
        q   = (a * a) / touch;
        mag = (longint'(stiff_q) * q) >> FRAC;
        sum_x = clamp_sum(sum_x + push_part(mag, dx, span));
        sum_y = clamp_sum(sum_y + push_part(mag, dy, span));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiff_q  <= 24'd327680;
      sum_x    = 0;
      sum_y    = 0;
      vel_q.delete();
      fails    = 0;
      end_seen = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) stiff_q <= cfg_data_i;
      if (s_tvalid_i && s_tready_i) begin
        if (!s_tuser_i) add_neighbor(s_tdata_i);
        if (s_tlast_i) begin
          vel_q.push_back({clamp_out(sum_y), clamp_out(sum_x)});
          sum_x = 0;
          sum_y = 0;
        end
      end
      if (m_tvalid_i && m_tready_i) begin
        if (vel_q.size() == 0) begin
          report("unexpected result", m_tdata_i[31:0], 32'h0);
        end else begin
          if (m_tdata_i[31:0] !== vel_q[0][31:0])
            report("vel_x", m_tdata_i[31:0], vel_q[0][31:0]);
          if (m_tdata_i[63:32] !== vel_q[0][63:32])
            report("vel_y", m_tdata_i[63:32], vel_q[0][63:32]);
          void'(vel_q.pop_front());
        end
      end
      if (end_i && !end_seen) begin
        end_seen = 1;
        if (vel_q.size() != 0) report("results missing", vel_q.size(), 32'h0);
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the contact repulsion velocity testbench: clock, reset, stimulus and verdict.
// Instantiates contact_repulsion_velocity and crv_checker side by side.
module testbench;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [23:0]  cfg_data = 0;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [175:0] s_tdata = 0;
  logic         s_tuser = 0;
  logic         s_tlast = 0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [63:0]  m_tdata;
  logic         end_run = 0;
  int           fail_count;
  int           pending;
  int           src_idle_pct;
  int           snk_idle_pct;
  int           sent_items;
  int           sent_frames;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  contact_repulsion_velocity u_dut (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready), .s_axis_tdata_i(s_tdata),
    .s_axis_tuser_i(s_tuser), .s_axis_tlast_i(s_tlast),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready), .m_axis_tdata_o(m_tdata)
  );

  crv_checker u_check (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .s_tvalid_i(s_tvalid), .s_tready_i(s_tready), .s_tdata_i(s_tdata),
    .s_tuser_i(s_tuser), .s_tlast_i(s_tlast),
    .m_tvalid_i(m_tvalid), .m_tready_i(m_tready), .m_tdata_i(m_tdata),
    .end_i(end_run), .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(negedge clk_i) m_tready <= ($urandom_range(99) >= snk_idle_pct);

  initial begin
    #60_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send(input logic [31:0] sx, input logic [31:0] sy, input logic [23:0] sr,
                      input logic [31:0] ox, input logic [31:0] oy, input logic [23:0] orad,
                      input logic self_flag, input logic last_flag);
    int gap;
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid = 0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid = 1;
    s_tdata  = {orad, oy, ox, sr, sy, sx};
    s_tuser  = self_flag;
    s_tlast  = last_flag;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
    s_tvalid = 0;
    sent_items++;
    if (last_flag) sent_frames++;
  endtask

  // Waits out the last result and the tail of any skipped neighbor still in flight.
  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic set_stiffness(input logic [23:0] v);
    drain();
    cfg_valid = 1;
    cfg_data  = v;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid = 0;
  endtask

  task automatic random_frame();
    int          n;
    int          kind;
    logic [31:0] sx, sy, ox, oy;
    logic [23:0] sr, orad;
    longint      t;
    logic        lst;
    n  = $urandom_range(1, 8);
    sx = $urandom;
    sy = $urandom;
    kind = $urandom_range(99);
    sr = 24'((kind < 80) ? $urandom_range(1, 1 << 20) : (kind < 92) ? $urandom : 32'd0);
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(99);
      orad = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 1 << 20));
      t  = longint'(sr) + longint'(orad);
      ox = sx + 32'(longint'($urandom_range(0, 32'(2 * t))) - t);
      oy = sy + 32'(longint'($urandom_range(0, 32'(2 * t))) - t);
      if (kind >= 70 && kind < 80) begin
        ox = $urandom;
        oy = $urandom;
      end else if (kind < 88 && kind >= 80) begin
        ox = sx;
        oy = sy;
      end else if (kind >= 94) begin
        ox = sx + 32'(t + 1);
      end
      lst = (i == n - 1) || ($urandom_range(99) < 3);
      send(sx, sy, sr, ox, oy, orad, (kind >= 88 && kind < 94), lst);
    end
  endtask

  initial begin
    src_idle_pct = 16;
    snk_idle_pct = 76;
    sent_items = 0;
    sent_frames = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed: skip cases, exact touch, both push directions, big overlaps.
    send(32'h0001_0000, 32'h0001_0000, 24'h01_0000, 32'h0001_8000, 32'h0001_0000, 24'h01_0000,
         1'b1, 1'b1);
    send(32'h0, 32'h0, 24'h01_0000, 32'h0003_0000, 32'h0, 24'h01_0000, 1'b0, 1'b1);
    send(32'h0, 32'h0, 24'h01_0000, 32'h0, 32'h0, 24'h01_0000, 1'b0, 1'b1);
    send(32'h0, 32'h0, 24'h01_0000, 32'h0002_0000, 32'h0, 24'h01_0000, 1'b0, 1'b1);
    send(32'h0, 32'h0, 24'h01_0000, 32'h0001_0000, 32'h0, 24'h01_0000, 1'b0, 1'b0);
    send(32'h0, 32'h0, 24'h01_0000, 32'hFFFF_8000, 32'h0000_4000, 24'h01_0000, 1'b0, 1'b0);
    send(32'h0, 32'h0, 24'h01_0000, 32'h0, 32'hFFFF_0000, 24'h01_0000, 1'b1, 1'b1);
    send(32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF, 32'h7FFF_FFFE, 32'h8000_0001, 24'hFF_FFFF,
         1'b0, 1'b1);
    set_stiffness(24'hFF_FFFF);
    send(32'h0, 32'h0, 24'hFF_FFFF, 32'h0000_0001, 32'h0000_0001, 24'hFF_FFFF, 1'b0, 1'b0);
    send(32'h0, 32'h0, 24'hFF_FFFF, 32'h0000_0002, 32'h0000_0000, 24'hFF_FFFF, 1'b0, 1'b0);
    send(32'h0, 32'h0, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 24'hFF_FFFF, 1'b0, 1'b1);
    send(32'h8000_0000, 32'h7FFF_FFFF, 24'h0, 32'h7FFF_FFFF, 32'h8000_0000, 24'h0, 1'b0, 1'b1);
    set_stiffness(24'h0);
    send(32'h0, 32'h0, 24'h01_0000, 32'h0000_8000, 32'h0, 24'h01_0000, 1'b0, 1'b1);

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 76 : 0;
      snk_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 16 : 0;
      set_stiffness((ph == 0) ? 24'hFF_FFFF : (ph == 1) ? 24'($urandom) : 24'd327680);
      for (int k = 0; k < 140; k++) begin
        random_frame();
        if (k == 70) begin
          drain();
          if (ph == 1) set_stiffness(24'h0);
        end
      end
    end

    drain();
    repeat (400) @(negedge clk_i);
    end_run = 1;
    @(negedge clk_i);
    $display("sent %0d neighbor requests in %0d focal runs", sent_items, sent_frames);
    $display("covered skip cases, saturation and stiffness 0, max and reset values");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
